### rtl/plt_pkg.sv
// Package for the peer learning table: result kinds, request codes, widths.
// No dependencies.
package plt_pkg;

    localparam int unsigned SER_W  = 64;
    localparam int unsigned IP_W   = 32;
    localparam int unsigned TIME_W = 63;
    localparam int unsigned TMO_W  = 32;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_SWEEP  = 2'd1,
        FUNC_LIST   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_REFRESH = 3'd0,
        KIND_ADDED   = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_REMOVED = 3'd3,
        KIND_LIST    = 3'd4,
        KIND_DONE    = 3'd5
    } t_kind;

    // One table entry as it travels along the cell row.
    typedef struct packed {
        logic              valid;
        logic [SER_W-1:0]  serial;
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] seen;
    } t_entry;

endpackage

### rtl/plt_if.sv
// Valid/ready channel interfaces for the peer learning table.
// Depends on plt_pkg.
interface plt_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic [plt_pkg::SER_W-1:0] serial;
    logic [plt_pkg::IP_W-1:0]  ip_addr;
    logic [plt_pkg::TIME_W-1:0] now_time;
    logic [4:0]                list_limit;
    modport source (output valid, func, serial, ip_addr, now_time, list_limit,
                    input ready);
    modport sink (input valid, func, serial, ip_addr, now_time, list_limit,
                  output ready);
endinterface

interface plt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 kind;
    logic [3:0]                 slot;
    logic [plt_pkg::SER_W-1:0]  peer_serial;
    logic [plt_pkg::IP_W-1:0]   peer_ip;
    logic [plt_pkg::TIME_W-1:0] last_seen;
    logic [4:0]                 count;
    logic                       last;
    modport source (output valid, kind, slot, peer_serial, peer_ip, last_seen,
                    count, last, input ready);
    modport sink (input valid, kind, slot, peer_serial, peer_ip, last_seen,
                  count, last, output ready);
endinterface

### rtl/plt_cell.sv
// One storage cell of the rotating entry row, with its own key compare.
// Depends on plt_pkg.
module plt_cell #(
    parameter bit RST_VALID = 1'b0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,    // take the neighbor entry
    input  plt_pkg::t_entry            i_next,     // entry of downstream neighbor
    input  logic                       i_wr,       // overwrite with i_wr_entry
    input  plt_pkg::t_entry            i_wr_entry,
    input  logic [plt_pkg::SER_W-1:0]  i_key,
    output plt_pkg::t_entry            o_entry,
    output logic                       o_match
);
    plt_pkg::t_entry r_entry, n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_wr) begin
            n_entry = i_wr_entry;
        end else if (i_shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= {RST_VALID, {($bits(plt_pkg::t_entry) - 1){1'b0}}};
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_entry.valid && (r_entry.serial == i_key);
endmodule

### rtl/peer_learning_table_with_aging_core.sv
// Peer learning table with aging: a row of SLOTS cells with parallel key compare.
// Update: one refresh, added or full result, then the done result.
// Sweep and list: SLOTS rotation steps, then the done result; the row holds while a
// waiting result holds the output register. Func 3: only the done result.
// Reset (sync, active low): slot 0 valid with zero contents, others clear,
// timeout 5000000. No clearing pass.
module peer_learning_table_with_aging_core #(
    parameter int unsigned SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    plt_req_if.sink     req,
    plt_rsp_if.source   rsp
);
    localparam int unsigned SW = $clog2(SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // The row rotates toward the head: cell 0 is the head and takes cell 1,
    // the tail takes the (possibly cleared) head entry. After SLOTS shifts the
    // table is back in place; r_idx names the slot in the head cell.
    plt_pkg::t_entry    cells [SLOTS];
    logic               match [SLOTS];
    plt_pkg::t_entry    feed;
    plt_pkg::t_entry    wr_entry;
    logic [SLOTS-1:0]   wr_vec;
    logic               shift;

    t_state r_state, n_state;
    logic [SW-1:0]              r_idx;
    logic [SW:0]                r_cnt;
    plt_pkg::t_func             r_func;
    logic [plt_pkg::SER_W-1:0]  r_ser;
    logic [plt_pkg::IP_W-1:0]   r_ip;
    logic [plt_pkg::TIME_W-1:0] r_now;
    logic [SW:0]                r_lim;
    logic [plt_pkg::TMO_W-1:0]  r_tmo;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        plt_cell #(.RST_VALID(g == 0)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (shift),
            .i_next    ((g == SLOTS - 1) ? feed : cells[(g + 1) % SLOTS]),
            .i_wr      (wr_vec[g]),
            .i_wr_entry(wr_entry),
            .i_key     (r_ser),
            .o_entry   (cells[g]),
            .o_match   (match[g])
        );
    end

    // Output register.
    logic                       r_ov;
    plt_pkg::t_kind             r_kind;
    logic [3:0]                 r_slot;
    logic [plt_pkg::SER_W-1:0]  r_oser;
    logic [plt_pkg::IP_W-1:0]   r_oip;
    logic [plt_pkg::TIME_W-1:0] r_oseen;
    logic [4:0]                 r_ocnt;
    logic                       r_olast;

    // Next values of the output register, valid when ld is set.
    logic                       ld;
    plt_pkg::t_kind             n_kind;
    logic [3:0]                 n_slot;
    logic [plt_pkg::SER_W-1:0]  n_oser;
    logic [plt_pkg::IP_W-1:0]   n_oip;
    logic [plt_pkg::TIME_W-1:0] n_oseen;
    logic [4:0]                 n_ocnt;
    logic                       n_olast;

    plt_pkg::t_entry head;
    logic out_free;
    logic expire, do_emit;
    logic hit, free;
    logic [SW-1:0] hit_slot, free_slot;
    logic [plt_pkg::TIME_W:0] age;

    assign head      = cells[0];
    assign out_free  = !r_ov || rsp.ready;
    assign req.ready = (r_state == ST_IDLE);

    // Age only counts when now is not before last-seen (borrow bit clear).
    assign age    = {1'b0, r_now} - {1'b0, head.seen};
    assign expire = head.valid && (head.serial != '0) && !age[plt_pkg::TIME_W]
                    && (age[plt_pkg::TIME_W-1:0] > {31'd0, r_tmo});

    // First matching valid slot and lowest free slot, all cells at once.
    always_comb begin
        hit       = 1'b0;
        free      = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit      = 1'b1;
                hit_slot = SW'(i);
            end
            if (!cells[i].valid) begin
                free      = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    always_comb begin
        wr_entry.valid  = 1'b1;
        wr_entry.serial = r_ser;
        wr_entry.ip     = r_ip;
        wr_entry.seen   = r_now;
    end

    // Emit condition for the entry at the head during a scan.
    always_comb begin
        unique case (r_func)
            plt_pkg::FUNC_SWEEP: do_emit = expire;
            plt_pkg::FUNC_LIST:  do_emit = head.valid && (r_cnt < r_lim);
            default:             do_emit = 1'b0;
        endcase
    end

    // Row control, result selection and state advance.
    always_comb begin
        n_state = r_state;
        shift   = 1'b0;
        feed    = head;
        wr_vec  = '0;
        ld      = 1'b0;
        n_kind  = plt_pkg::KIND_DONE;
        n_slot  = '0;
        n_oser  = '0;
        n_oip   = '0;
        n_oseen = '0;
        n_ocnt  = '0;
        n_olast = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (req.valid) begin
                    unique case (plt_pkg::t_func'(req.func)) inside
                        plt_pkg::FUNC_UPDATE:                    n_state = ST_UPD;
                        plt_pkg::FUNC_SWEEP, plt_pkg::FUNC_LIST: n_state = ST_SCAN;
                        default:                                 n_state = ST_DONE;
                    endcase
                end
            end
            ST_UPD: begin
                // Refresh, add and full all report the request's own contents.
                if (out_free) begin
                    ld      = 1'b1;
                    n_oser  = r_ser;
                    n_oip   = r_ip;
                    n_oseen = r_now;
                    if (hit) begin
                        n_kind           = plt_pkg::KIND_REFRESH;
                        n_slot           = 4'(hit_slot);
                        wr_vec[hit_slot] = 1'b1;
                    end else if (free) begin
                        n_kind            = plt_pkg::KIND_ADDED;
                        n_slot            = 4'(free_slot);
                        wr_vec[free_slot] = 1'b1;
                    end else begin
                        n_kind = plt_pkg::KIND_FULL;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                // Hold the row while a result for the head waits for room.
                if (!do_emit || out_free) begin
                    shift = 1'b1;
                    if (do_emit) begin
                        ld      = 1'b1;
                        n_kind  = (r_func == plt_pkg::FUNC_SWEEP) ? plt_pkg::KIND_REMOVED
                                                                  : plt_pkg::KIND_LIST;
                        n_slot  = 4'(r_idx);
                        n_oser  = head.serial;
                        n_oip   = head.ip;
                        n_oseen = head.seen;
                        if (r_func == plt_pkg::FUNC_SWEEP) begin
                            // Drop: the head entry goes around invalid.
                            feed.valid = 1'b0;
                        end
                    end
                    if (r_idx == SW'(SLOTS - 1)) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ld      = 1'b1;
                    n_kind  = plt_pkg::KIND_DONE;
                    n_ocnt  = 5'(r_cnt);
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tmo   <= 32'd5000000;
            r_ov    <= 1'b0;
            r_kind  <= plt_pkg::KIND_DONE;
            r_slot  <= '0;
            r_oser  <= '0;
            r_oip   <= '0;
            r_oseen <= '0;
            r_ocnt  <= '0;
            r_olast <= 1'b0;
            r_func  <= plt_pkg::FUNC_NONE;
            r_ser   <= '0;
            r_ip    <= '0;
            r_now   <= '0;
            r_lim   <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tmo <= i_cfg_wdata;
            end
            if (ld) begin
                r_ov    <= 1'b1;
                r_kind  <= n_kind;
                r_slot  <= n_slot;
                r_oser  <= n_oser;
                r_oip   <= n_oip;
                r_oseen <= n_oseen;
                r_ocnt  <= n_ocnt;
                r_olast <= n_olast;
            end else if (rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (req.valid) begin
                        r_func <= plt_pkg::t_func'(req.func);
                        r_ser  <= req.serial;
                        r_ip   <= req.ip_addr;
                        r_now  <= req.now_time;
                        r_lim  <= (32'(req.list_limit) > SLOTS) ? (SW+1)'(SLOTS)
                                                                : (SW+1)'(req.list_limit);
                        r_idx  <= '0;
                        r_cnt  <= '0;
                    end
                end
                ST_UPD: begin
                    if (out_free) begin
                        r_cnt <= (hit || free) ? (SW+1)'(1) : '0;
                    end
                end
                ST_SCAN: begin
                    if (shift) begin
                        r_idx <= r_idx + SW'(1);
                        if (ld) begin
                            r_cnt <= r_cnt + (SW+1)'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign rsp.valid       = r_ov;
    assign rsp.kind        = r_kind;
    assign rsp.slot        = r_slot;
    assign rsp.peer_serial = r_oser;
    assign rsp.peer_ip     = r_oip;
    assign rsp.last_seen   = r_oseen;
    assign rsp.count       = r_ocnt;
    assign rsp.last        = r_olast;
endmodule
